/* hw/rtl/cpt2_pkg.sv */
// Shared constants for the 2-D closest-point-on-triangle pipeline.
// No dependencies.
`default_nettype none
package cpt2_pkg;
    // fraction bits of the edge parameter q
    localparam int EDGE_FRAC = 32;
endpackage
`default_nettype wire

/* hw/rtl/cpt2_if.sv */
// Stream interfaces: query word (triangle + point) and result word (point).
// Depend on nothing; valid/ready handshake.
`default_nettype none
interface cpt2_query_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] query_x;
    logic signed [COORD_WIDTH-1:0] query_y;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                    vertex_c_x, vertex_c_y, query_x, query_y, input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
                  vertex_c_x, vertex_c_y, query_x, query_y, output ready);
endinterface

interface cpt2_point_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] closest_x;
    logic signed [COORD_WIDTH-1:0] closest_y;

    modport source (output valid, closest_x, closest_y, input ready);
    modport sink (input valid, closest_x, closest_y, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cpt2_geom.sv */
// Geometry front end: differences, products, dot/cross sums, region select.
// Four register stages; uses no package items.
`default_nettype none
module cpt2_geom #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] ax,
    input  wire logic signed [COORD_WIDTH-1:0] ay,
    input  wire logic signed [COORD_WIDTH-1:0] bx,
    input  wire logic signed [COORD_WIDTH-1:0] by,
    input  wire logic signed [COORD_WIDTH-1:0] cx,
    input  wire logic signed [COORD_WIDTH-1:0] cy,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [2*COORD_WIDTH+3:0]           num,
    output logic [2*COORD_WIDTH+3:0]           den,
    output logic [COORD_WIDTH-1:0]             vx,
    output logic [COORD_WIDTH-1:0]             vy,
    output logic signed [COORD_WIDTH:0]        ex,
    output logic signed [COORD_WIDTH:0]        ey
);
    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int SW = 2 * W + 3;
    localparam int DW = 2 * W + 4;

    typedef logic signed [W-1:0] crd_t;
    typedef logic signed [W:0]   dif_t;

    function automatic dif_t sub1(input crd_t a, input crd_t b);
        return {a[W-1], a} - {b[W-1], b};
    endfunction

    function automatic logic le0(input logic signed [SW-1:0] v);
        return v[SW-1] || (v == '0);
    endfunction

    // orientation times area sign is not positive
    function automatic logic area_ok(input logic signed [SW-1:0] o,
                                     input logic signed [SW-1:0] a);
        return !((|o) && (|a) && (o[SW-1] == a[SW-1]));
    endfunction

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: differences
    dif_t s1_pa_reg [2];
    dif_t s1_pb_reg [2];
    dif_t s1_ap_reg [2];
    dif_t s1_bp_reg [2];
    dif_t s1_cp_reg [2];
    dif_t s1_ab_reg [2];
    dif_t s1_bc_reg [2];
    dif_t s1_ac_reg [2];
    crd_t s1_crd_reg [8];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pa_reg[0] <= sub1(px, ax);
            s1_pa_reg[1] <= sub1(py, ay);
            s1_pb_reg[0] <= sub1(px, bx);
            s1_pb_reg[1] <= sub1(py, by);
            s1_ap_reg[0] <= sub1(ax, px);
            s1_ap_reg[1] <= sub1(ay, py);
            s1_bp_reg[0] <= sub1(bx, px);
            s1_bp_reg[1] <= sub1(by, py);
            s1_cp_reg[0] <= sub1(cx, px);
            s1_cp_reg[1] <= sub1(cy, py);
            s1_ab_reg[0] <= sub1(bx, ax);
            s1_ab_reg[1] <= sub1(by, ay);
            s1_bc_reg[0] <= sub1(cx, bx);
            s1_bc_reg[1] <= sub1(cy, by);
            s1_ac_reg[0] <= sub1(cx, ax);
            s1_ac_reg[1] <= sub1(cy, ay);
            s1_crd_reg[0] <= ax;
            s1_crd_reg[1] <= ay;
            s1_crd_reg[2] <= bx;
            s1_crd_reg[3] <= by;
            s1_crd_reg[4] <= cx;
            s1_crd_reg[5] <= cy;
            s1_crd_reg[6] <= px;
            s1_crd_reg[7] <= py;
        end
    end

    // stage 2: products, pairs (2i, 2i+1) form sum i
    logic signed [PW-1:0] mul_next [20];
    logic signed [PW-1:0] s2_mul_reg [20];
    crd_t s2_crd_reg [8];
    dif_t s2_ab_reg [2];
    dif_t s2_ac_reg [2];
    dif_t s2_bc_reg [2];

    always_comb
    begin
        mul_next[0]  = s1_pa_reg[0] * s1_ab_reg[0];
        mul_next[1]  = s1_pa_reg[1] * s1_ab_reg[1];
        mul_next[2]  = s1_bp_reg[0] * s1_ab_reg[0];
        mul_next[3]  = s1_bp_reg[1] * s1_ab_reg[1];
        mul_next[4]  = s1_pb_reg[0] * s1_bc_reg[0];
        mul_next[5]  = s1_pb_reg[1] * s1_bc_reg[1];
        mul_next[6]  = s1_cp_reg[0] * s1_bc_reg[0];
        mul_next[7]  = s1_cp_reg[1] * s1_bc_reg[1];
        mul_next[8]  = s1_pa_reg[0] * s1_ac_reg[0];
        mul_next[9]  = s1_pa_reg[1] * s1_ac_reg[1];
        mul_next[10] = s1_cp_reg[0] * s1_ac_reg[0];
        mul_next[11] = s1_cp_reg[1] * s1_ac_reg[1];
        mul_next[12] = s1_ab_reg[0] * s1_ac_reg[1];
        mul_next[13] = s1_ab_reg[1] * s1_ac_reg[0];
        mul_next[14] = s1_ap_reg[0] * s1_bp_reg[1];
        mul_next[15] = s1_ap_reg[1] * s1_bp_reg[0];
        mul_next[16] = s1_bp_reg[0] * s1_cp_reg[1];
        mul_next[17] = s1_bp_reg[1] * s1_cp_reg[0];
        mul_next[18] = s1_cp_reg[0] * s1_ap_reg[1];
        mul_next[19] = s1_cp_reg[1] * s1_ap_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_mul_reg <= mul_next;
            s2_crd_reg <= s1_crd_reg;
            s2_ab_reg  <= s1_ab_reg;
            s2_bc_reg  <= s1_bc_reg;
            s2_ac_reg  <= s1_ac_reg;
        end
    end

    // stage 3: sums; 0..5 dots, 6 orientation, 7..9 edge areas
    logic signed [SW-1:0] sum_next [10];
    logic signed [SW-1:0] s3_sum_reg [10];
    crd_t s3_crd_reg [8];
    dif_t s3_ab_reg [2];
    dif_t s3_ac_reg [2];
    dif_t s3_bc_reg [2];

    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            if (i < 6)
                sum_next[i] = {s2_mul_reg[2*i][PW-1], s2_mul_reg[2*i]}
                            + {s2_mul_reg[2*i+1][PW-1], s2_mul_reg[2*i+1]};
            else
                sum_next[i] = {s2_mul_reg[2*i][PW-1], s2_mul_reg[2*i]}
                            - {s2_mul_reg[2*i+1][PW-1], s2_mul_reg[2*i+1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_sum_reg <= sum_next;
            s3_crd_reg <= s2_crd_reg;
            s3_ab_reg  <= s2_ab_reg;
            s3_bc_reg  <= s2_bc_reg;
            s3_ac_reg  <= s2_ac_reg;
        end
    end

    // stage 4: region select
    logic signed [SW-1:0] sel_num, sel_oth;
    crd_t sel_vx, sel_vy;
    dif_t sel_ex, sel_ey;
    logic [DW-1:0] s4_num_reg, s4_den_reg;
    crd_t s4_vx_reg, s4_vy_reg;
    dif_t s4_ex_reg, s4_ey_reg;

    always_comb
    begin
        sel_num = '0;
        sel_oth = '0;
        sel_vx  = s3_crd_reg[6];
        sel_vy  = s3_crd_reg[7];
        sel_ex  = '0;
        sel_ey  = '0;
        if (le0(s3_sum_reg[0]) && le0(s3_sum_reg[4]))
        begin
            sel_vx = s3_crd_reg[0];
            sel_vy = s3_crd_reg[1];
        end
        else if (le0(s3_sum_reg[1]) && le0(s3_sum_reg[2]))
        begin
            sel_vx = s3_crd_reg[2];
            sel_vy = s3_crd_reg[3];
        end
        else if (le0(s3_sum_reg[5]) && le0(s3_sum_reg[3]))
        begin
            sel_vx = s3_crd_reg[4];
            sel_vy = s3_crd_reg[5];
        end
        else if (!le0(s3_sum_reg[0]) && !le0(s3_sum_reg[1])
                 && area_ok(s3_sum_reg[6], s3_sum_reg[7]))
        begin
            sel_num = s3_sum_reg[0];
            sel_oth = s3_sum_reg[1];
            sel_vx  = s3_crd_reg[0];
            sel_vy  = s3_crd_reg[1];
            sel_ex  = s3_ab_reg[0];
            sel_ey  = s3_ab_reg[1];
        end
        else if (!le0(s3_sum_reg[2]) && !le0(s3_sum_reg[3])
                 && area_ok(s3_sum_reg[6], s3_sum_reg[8]))
        begin
            sel_num = s3_sum_reg[2];
            sel_oth = s3_sum_reg[3];
            sel_vx  = s3_crd_reg[2];
            sel_vy  = s3_crd_reg[3];
            sel_ex  = s3_bc_reg[0];
            sel_ey  = s3_bc_reg[1];
        end
        else if (!le0(s3_sum_reg[4]) && !le0(s3_sum_reg[5])
                 && area_ok(s3_sum_reg[6], s3_sum_reg[9]))
        begin
            sel_num = s3_sum_reg[4];
            sel_oth = s3_sum_reg[5];
            sel_vx  = s3_crd_reg[0];
            sel_vy  = s3_crd_reg[1];
            sel_ex  = s3_ac_reg[0];
            sel_ey  = s3_ac_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_num_reg <= {sel_num[SW-1], sel_num};
            s4_den_reg <= {sel_num[SW-1], sel_num} + {sel_oth[SW-1], sel_oth};
            s4_vx_reg  <= sel_vx;
            s4_vy_reg  <= sel_vy;
            s4_ex_reg  <= sel_ex;
            s4_ey_reg  <= sel_ey;
        end
    end

    assign num = s4_num_reg;
    assign den = s4_den_reg;
    assign vx  = s4_vx_reg;
    assign vy  = s4_vy_reg;
    assign ex  = s4_ex_reg;
    assign ey  = s4_ey_reg;

    a_num_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (s4_num_reg < s4_den_reg) || (s4_num_reg == '0))
        else $error("edge numerator not below divisor");
    a_vertex_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && (s4_num_reg == '0) |-> (s4_ex_reg == '0) && (s4_ey_reg == '0))
        else $error("vertex or inside word carries an edge vector");
endmodule
`default_nettype wire

/* hw/rtl/cpt2_div.sv */
// Pipelined restoring divider, one quotient bit per stage: q = num*2^F/den.
// Depends on cpt2_pkg (EDGE_FRAC).
`default_nettype none
module cpt2_div #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2*COORD_WIDTH+3:0]    num,
    input  wire logic [2*COORD_WIDTH+3:0]    den,
    input  wire logic [COORD_WIDTH-1:0]      vx_in,
    input  wire logic [COORD_WIDTH-1:0]      vy_in,
    input  wire logic signed [COORD_WIDTH:0] ex_in,
    input  wire logic signed [COORD_WIDTH:0] ey_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cpt2_pkg::EDGE_FRAC-1:0]   q,
    output logic [COORD_WIDTH-1:0]           vx_out,
    output logic [COORD_WIDTH-1:0]           vy_out,
    output logic signed [COORD_WIDTH:0]      ex_out,
    output logic signed [COORD_WIDTH:0]      ey_out
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 4;
    localparam int EF = cpt2_pkg::EDGE_FRAC;

    logic [EF-1:0] v_reg;
    logic [EF:0]   en;
    logic [DW-1:0] r_reg [EF];
    logic [DW-1:0] d_reg [EF];
    logic [EF-1:0] q_reg [EF];
    logic [W-1:0]  vx_reg [EF];
    logic [W-1:0]  vy_reg [EF];
    logic signed [W:0] ex_reg [EF];
    logic signed [W:0] ey_reg [EF];

    assign en[EF]    = out_ready;
    assign in_ready  = en[0];
    assign out_valid = v_reg[EF-1];

    genvar k;
    for (k = 0; k < EF; k++)
    begin : g_step
        logic          src_v;
        logic [DW-1:0] r_src, d_src;
        logic [EF-1:0] q_src;
        logic [W-1:0]  vx_src, vy_src;
        logic signed [W:0] ex_src, ey_src;
        logic [DW:0]   shl;
        logic [DW+1:0] dif;

        if (k == 0)
        begin : g_first
            assign src_v  = in_valid;
            assign r_src  = num;
            assign d_src  = den;
            assign q_src  = '0;
            assign vx_src = vx_in;
            assign vy_src = vy_in;
            assign ex_src = ex_in;
            assign ey_src = ey_in;
        end
        else
        begin : g_rest
            assign src_v  = v_reg[k-1];
            assign r_src  = r_reg[k-1];
            assign d_src  = d_reg[k-1];
            assign q_src  = q_reg[k-1];
            assign vx_src = vx_reg[k-1];
            assign vy_src = vy_reg[k-1];
            assign ex_src = ex_reg[k-1];
            assign ey_src = ey_reg[k-1];
        end

        assign en[k] = !v_reg[k] || en[k+1];
        assign shl   = {r_src, 1'b0};
        assign dif   = {1'b0, shl} - {2'b00, d_src};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                if (!dif[DW+1])
                begin
                    r_reg[k] <= dif[DW-1:0];
                    q_reg[k] <= {q_src[EF-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k] <= shl[DW-1:0];
                    q_reg[k] <= {q_src[EF-2:0], 1'b0};
                end
                d_reg[k]  <= d_src;
                vx_reg[k] <= vx_src;
                vy_reg[k] <= vy_src;
                ex_reg[k] <= ex_src;
                ey_reg[k] <= ey_src;
            end
        end
    end

    assign q      = q_reg[EF-1];
    assign vx_out = vx_reg[EF-1];
    assign vy_out = vy_reg[EF-1];
    assign ex_out = ex_reg[EF-1];
    assign ey_out = ey_reg[EF-1];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[EF-1] |-> (r_reg[EF-1] < d_reg[EF-1]) || (d_reg[EF-1] == '0))
        else $error("divider remainder not below divisor");
endmodule
`default_nettype wire

/* hw/rtl/cpt2_edge.sv */
// Edge point: v + floor(q * e / 2^F) per axis, multiply then add stage.
// Depends on cpt2_pkg (EDGE_FRAC).
`default_nettype none
module cpt2_edge #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [cpt2_pkg::EDGE_FRAC-1:0] q,
    input  wire logic [COORD_WIDTH-1:0]      vx,
    input  wire logic [COORD_WIDTH-1:0]      vy,
    input  wire logic signed [COORD_WIDTH:0] ex,
    input  wire logic signed [COORD_WIDTH:0] ey,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [COORD_WIDTH-1:0]           rx,
    output logic [COORD_WIDTH-1:0]           ry
);
    localparam int W  = COORD_WIDTH;
    localparam int EF = cpt2_pkg::EDGE_FRAC;
    localparam int MW = W + EF + 2;

    logic v1_reg, v2_reg, en1, en2;
    logic signed [MW-1:0] s1_px_reg, s1_py_reg;
    logic [W-1:0] s1_vx_reg, s1_vy_reg;
    logic s1_exs_reg;
    logic [W-1:0] s2_rx_reg, s2_ry_reg;

    assign en2 = !v2_reg || out_ready;
    assign en1 = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_px_reg  <= $signed({1'b0, q}) * ex;
            s1_py_reg  <= $signed({1'b0, q}) * ey;
            s1_vx_reg  <= vx;
            s1_vy_reg  <= vy;
            s1_exs_reg <= ex[W];
        end
        if (en2)
        begin
            s2_rx_reg <= s1_vx_reg + s1_px_reg[EF +: W];
            s2_ry_reg <= s1_vy_reg + s1_py_reg[EF +: W];
        end
    end

    assign rx = s2_rx_reg;
    assign ry = s2_ry_reg;

    a_offset_sign: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !s1_exs_reg |-> !s1_px_reg[MW-1])
        else $error("edge offset sign flipped");
endmodule
`default_nettype wire

/* hw/rtl/closest_point_on_triangle_2d_core.sv */
// Top level of the 2-D closest-point-on-triangle pipeline.
// Depends on cpt2_pkg, cpt2_if, cpt2_geom, cpt2_div, cpt2_edge.
//
// Usage:
//   query (sink): one word holds vertices A, B, C and the query point, signed
//   fixed point. point (source): one word with the closest point of the solid
//   triangle. One result word per query word, in order.
//   Stages: geometry, divider (one quotient bit per stage, EDGE_FRAC of them), edge.
//   Throughput: one word per cycle while point.ready is high; every
//   stage holds its own valid bit.
//   Stall: when point.ready is low the words pile up against the output;
//   query.ready stays high while any stage still has a bubble to fill.
//   Reset: rst_n clears all valid bits; the pipeline comes up empty and
//   ready.
`default_nettype none
module closest_point_on_triangle_2d_core #(
    parameter int COORD_WIDTH = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    cpt2_query_if.sink   query,
    cpt2_point_if.source point
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = 2 * W + 4;

    logic          g_valid, g_ready, d_valid, d_ready;
    logic [DW-1:0] g_num, g_den;
    logic [W-1:0]  g_vx, g_vy, d_vx, d_vy, r_x, r_y;
    logic signed [W:0] g_ex, g_ey, d_ex, d_ey;
    logic [cpt2_pkg::EDGE_FRAC-1:0] d_q;

    cpt2_geom #(.COORD_WIDTH(W)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .ax        (query.vertex_a_x),
        .ay        (query.vertex_a_y),
        .bx        (query.vertex_b_x),
        .by        (query.vertex_b_y),
        .cx        (query.vertex_c_x),
        .cy        (query.vertex_c_y),
        .px        (query.query_x),
        .py        (query.query_y),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .num       (g_num),
        .den       (g_den),
        .vx        (g_vx),
        .vy        (g_vy),
        .ex        (g_ex),
        .ey        (g_ey)
    );

    cpt2_div #(.COORD_WIDTH(W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .num       (g_num),
        .den       (g_den),
        .vx_in     (g_vx),
        .vy_in     (g_vy),
        .ex_in     (g_ex),
        .ey_in     (g_ey),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .q         (d_q),
        .vx_out    (d_vx),
        .vy_out    (d_vy),
        .ex_out    (d_ex),
        .ey_out    (d_ey)
    );

    cpt2_edge #(.COORD_WIDTH(W)) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .q         (d_q),
        .vx        (d_vx),
        .vy        (d_vy),
        .ex        (d_ex),
        .ey        (d_ey),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .rx        (r_x),
        .ry        (r_y)
    );

    assign point.closest_x = $signed(r_x);
    assign point.closest_y = $signed(r_y);

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !g_valid && !d_valid && !point.valid && point.ready |-> query.ready)
        else $error("drained pipeline refuses input");
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for closest_point_on_triangle_2d_core: a table of directed queries,
// then random triangles, each point checked against an in-bench predictor.
// Depends on cpt2_pkg, cpt2_if and the core RTL.
`timescale 1ns / 1ps
module tb;
    localparam int W         = 32;
    localparam int U         = 65536;
    localparam int N_RANDOM  = 1835;
    localparam int HOLD_LEN  = 300;
    localparam int CYC_LIMIT = 600000;
    localparam int DRAIN     = 60;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [W-1:0] c[8];
    } query_t;

    typedef struct {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
    } point_t;

    typedef struct {
        int  c[8];
        bit  known;
        int  ex;
        int  ey;
    } row_t;

    localparam int MN = 32'h80000000;
    localparam int MX = 32'h7fffffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cpt2_query_if #(.COORD_WIDTH(W)) query();
    cpt2_point_if #(.COORD_WIDTH(W)) point();

    closest_point_on_triangle_2d_core #(.COORD_WIDTH(W)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .query (query),
        .point (point)
    );

    always #4 clk = ~clk;

    point_t expected_pts[$];
    int     errors = 0;
    int     cycles = 0;
    int     phase = 0;
    bit     hold_req = 1'b0;

    row_t dir_rows[14] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, 0, 0},
        '{'{0, 0, 10*U, 0, 0, 10*U, -5*U, -5*U}, 1'b1, 0, 0},
        '{'{0, 0, 10*U, 0, 0, 10*U, 15*U, -2*U}, 1'b1, 10*U, 0},
        '{'{0, 0, 10*U, 0, 0, 10*U, -1*U, 15*U}, 1'b1, 0, 10*U},
        '{'{0, 0, 10*U, 0, 0, 10*U, 2*U, 3*U}, 1'b1, 2*U, 3*U},
        '{'{0, 0, 10*U, 0, 0, 10*U, 4*U, -3*U}, 1'b0, 0, 0},
        '{'{0, 0, 10*U, 0, 0, 10*U, 7*U, 7*U}, 1'b0, 0, 0},
        '{'{0, 0, 10*U, 0, 0, 10*U, -3*U, 4*U}, 1'b0, 0, 0},
        '{'{0, 0, 0, 10*U, 10*U, 0, 3*U, -2*U}, 1'b0, 0, 0},
        '{'{0, 0, 5*U, 5*U, 10*U, 10*U, 3*U, 1*U}, 1'b0, 0, 0},
        '{'{7*U, -3*U, 7*U, -3*U, 7*U, -3*U, 12345, -999}, 1'b1, 7*U, -3*U},
        '{'{MN, MN, MN, MN, MN, MN, MX, MX}, 1'b1, MN, MN},
        '{'{MX, MX, MX, MX, MX, MX, MN, MN}, 1'b1, MX, MX},
        '{'{MN, MN, MX, MN, MN, MX, MX, MX}, 1'b0, 0, 0}
    };

    function automatic int sgn(wide_t v);
        if (v < 0)
            return -1;
        return (v != 0) ? 1 : 0;
    endfunction

    function automatic wide_t dot(longint ax, longint ay, longint bx, longint by);
        wide_t wax, way, wbx, wby;
        wax = ax; way = ay; wbx = bx; wby = by;
        return wax * wbx + way * wby;
    endfunction

    function automatic wide_t cross2(longint ax, longint ay, longint bx, longint by);
        wide_t wax, way, wbx, wby;
        wax = ax; way = ay; wbx = bx; wby = by;
        return wax * wby - way * wbx;
    endfunction

    function automatic logic signed [W-1:0] lerp_coord(longint v, longint e, wide_t q);
        wide_t wv, we, p;
        wv = v; we = e;
        p = q * we;
        p = wv + (p >>> cpt2_pkg::EDGE_FRAC);
        return p[W-1:0];
    endfunction

    function automatic point_t closest_point(query_t t);
        longint ax, ay, bx, by, cx, cy, px, py;
        longint abx, aby, acx, acy, bcx, bcy;
        wide_t s_ab, s_ba, t_bc, t_cb, u_ac, u_ca, q;
        int sn;
        point_t r;
        ax = t.c[0]; ay = t.c[1]; bx = t.c[2]; by = t.c[3];
        cx = t.c[4]; cy = t.c[5]; px = t.c[6]; py = t.c[7];
        abx = bx - ax; aby = by - ay;
        acx = cx - ax; acy = cy - ay;
        bcx = cx - bx; bcy = cy - by;
        s_ab = dot(px - ax, py - ay, abx, aby);
        s_ba = dot(px - bx, py - by, -abx, -aby);
        t_bc = dot(px - bx, py - by, bcx, bcy);
        t_cb = dot(px - cx, py - cy, -bcx, -bcy);
        u_ac = dot(px - ax, py - ay, acx, acy);
        u_ca = dot(px - cx, py - cy, -acx, -acy);
        r.x = t.c[6];
        r.y = t.c[7];
        sn = sgn(cross2(abx, aby, acx, acy));
        if (sgn(s_ab) <= 0 && sgn(u_ac) <= 0)
        begin
            r.x = t.c[0]; r.y = t.c[1];
        end
        else if (sgn(s_ba) <= 0 && sgn(t_bc) <= 0)
        begin
            r.x = t.c[2]; r.y = t.c[3];
        end
        else if (sgn(u_ca) <= 0 && sgn(t_cb) <= 0)
        begin
            r.x = t.c[4]; r.y = t.c[5];
        end
        else if (s_ab > 0 && s_ba > 0 &&
                 sn * sgn(cross2(ax - px, ay - py, bx - px, by - py)) <= 0)
        begin
            q = (s_ab <<< cpt2_pkg::EDGE_FRAC) / (s_ab + s_ba);
            r.x = lerp_coord(ax, abx, q);
            r.y = lerp_coord(ay, aby, q);
        end
        else if (t_bc > 0 && t_cb > 0 &&
                 sn * sgn(cross2(bx - px, by - py, cx - px, cy - py)) <= 0)
        begin
            q = (t_bc <<< cpt2_pkg::EDGE_FRAC) / (t_bc + t_cb);
            r.x = lerp_coord(bx, bcx, q);
            r.y = lerp_coord(by, bcy, q);
        end
        else if (u_ac > 0 && u_ca > 0 &&
                 sn * sgn(cross2(cx - px, cy - py, ax - px, ay - py)) <= 0)
        begin
            q = (u_ac <<< cpt2_pkg::EDGE_FRAC) / (u_ac + u_ca);
            r.x = lerp_coord(ax, acx, q);
            r.y = lerp_coord(ay, acy, q);
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] rand_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom;
        if (sel == 1)
            return $urandom_range(0, 1) ? MX : MN;
        return ($urandom_range(0, 400) - 200) * U + ($urandom & 16'hffff);
    endfunction

    function automatic query_t rand_query();
        query_t t;
        int k;
        for (int i = 0; i < 8; i++)
            t.c[i] = rand_coord();
        case ($urandom_range(0, 9))
            0:
            begin
                k = $urandom_range(0, 6) - 3;
                t.c[4] = t.c[0] + k * (t.c[2] - t.c[0]) / 2;
                t.c[5] = t.c[1] + k * (t.c[3] - t.c[1]) / 2;
            end
            1:
            begin
                t.c[2] = t.c[0];
                t.c[3] = t.c[1];
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout");
            $display("Verification failed");
            $finish;
        end
    end

    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            point.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            point.ready <= 1'b0;
        end
        else
        begin
            case (phase)
                0: point.ready <= ($urandom_range(0, 99) >= 50);
                1: point.ready <= ($urandom_range(0, 99) >= 18);
                default: point.ready <= 1'b1;
            endcase
        end
    end

    int out_idx = 0;
    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && point.valid && point.ready)
        begin
            if (expected_pts.size() == 0)
            begin
                report($sformatf("unexpected point word %0d", out_idx));
            end
            else
            begin
                e = expected_pts.pop_front();
                if (point.closest_x !== e.x)
                    report($sformatf("closest_x word %0d: got %h expected %h",
                                     out_idx, point.closest_x, e.x));
                if (point.closest_y !== e.y)
                    report($sformatf("closest_y word %0d: got %h expected %h",
                                     out_idx, point.closest_y, e.y));
            end
            out_idx++;
        end
    end

    task automatic send_query(query_t t);
        point_t e;
        if (phase == 0 ? ($urandom_range(0, 99) < 18) :
            phase == 1 ? ($urandom_range(0, 99) < 50) : 1'b0)
        begin
            query.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 40);
        end
        query.valid      <= 1'b1;
        query.vertex_a_x <= t.c[0];
        query.vertex_a_y <= t.c[1];
        query.vertex_b_x <= t.c[2];
        query.vertex_b_y <= t.c[3];
        query.vertex_c_x <= t.c[4];
        query.vertex_c_y <= t.c[5];
        query.query_x    <= t.c[6];
        query.query_y    <= t.c[7];
        do
            @(posedge clk);
        while (!query.ready);
        e = closest_point(t);
        expected_pts.push_back(e);
    endtask

    initial
    begin
        query_t t;
        point_t e;
        query.valid      = 1'b0;
        query.vertex_a_x = '0;
        query.vertex_a_y = '0;
        query.vertex_b_x = '0;
        query.vertex_b_y = '0;
        query.vertex_c_x = '0;
        query.vertex_c_y = '0;
        query.query_x    = '0;
        query.query_y    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            for (int k = 0; k < 8; k++)
                t.c[k] = dir_rows[i].c[k];
            if (dir_rows[i].known)
            begin
                e = closest_point(t);
                if (e.x !== dir_rows[i].ex || e.y !== dir_rows[i].ey)
                    report($sformatf("predictor disagrees with table row %0d", i));
            end
            send_query(t);
        end

        // let the pipeline run dry before the random part
        query.valid <= 1'b0;
        while (expected_pts.size() != 0)
            @(posedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
                phase = 1;
            if (n == 2 * N_RANDOM / 3)
            begin
                phase = 2;
                hold_req = 1'b1;
            end
            send_query(rand_query());
        end
        query.valid <= 1'b0;

        while (expected_pts.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
